FILE: rtl/core/fbpa_pkg.sv
// Shared constants for the fixed block pool allocator.
// Field widths, stream packing, register indexes and status codes.
// No dependencies.
package fbpa_pkg;

  // pool geometry
  localparam int NUM_CHUNKS = 256;
  localparam int IDX_W      = $clog2(NUM_CHUNKS);
  localparam int DEPTH_W    = $clog2(NUM_CHUNKS + 1);
  localparam int STEP_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  // field widths
  localparam int CS_W          = 13;
  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 16;
  localparam int CNT_W         = 32;
  localparam int STATUS_W      = 3;
  localparam int BYTES_W       = 21;
  localparam int INDEX_FIELD_W = 8;
  localparam int FREE_FIELD_W  = 9;

  // divider and multiplier widths
  localparam int REM_W  = CS_W + IDX_W;
  localparam int PROD_W = CS_W + DEPTH_W;

  // stream packing
  localparam int S_TDATA_W = 48;
  localparam int M_TUSER_W = STATUS_W;
  localparam int OUT_BITS  = INDEX_FIELD_W + ADDR_W + FREE_FIELD_W + 2 * CNT_W + BYTES_W;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int FREE_LSB  = INDEX_FIELD_W + ADDR_W;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POOL_BASE  = 1'd1;
  localparam logic [CS_W-1:0]        CS_RESET       = 13'd64;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd4;

endpackage

FILE: rtl/core/fbpa_ram.sv
// Generic single-port RAM with registered read data.
// Used for the free index stack; no package dependency.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/fixed_block_pool_allocator.sv
// Fixed block pool allocator: LIFO stack of free chunk indices in a RAM.
// An allocate pops the stack and reads the entry; a free range-checks the address, divides
// its offset by the chunk size in an 8-step divider, checks the quotient and stack, then pushes.
// Both then use a shared multiplier for address and bytes in use; one item in flight at a time.
// Reset (rst, synchronous): stack full with entry i holding i via per-entry valid bits,
// counters zero, chunk_size 64, pool_base 0; no clearing pass.
module fixed_block_pool_allocator (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fbpa_pkg::S_TDATA_W-1:0]  s_tdata,  // request_size[15:0], free_address[47:16]
  input  logic                            s_tuser,  // req_type
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fbpa_pkg::M_TDATA_W-1:0]  m_tdata,  // chunk_index, chunk_address, chunks_free,
                                                    // alloc_total, free_total, bytes_in_use
  output logic [fbpa_pkg::M_TUSER_W-1:0]  m_tuser   // status
);

  import fbpa_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_DIV_END  = 3'd3;
  localparam logic [2:0] S_ALLOC_RD = 3'd4;
  localparam logic [2:0] S_MUL_ADDR = 3'd5;
  localparam logic [2:0] S_MUL_USED = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]          state;
  logic [CS_W-1:0]     chunk_size;
  logic [ADDR_W-1:0]   pool_base;
  logic [DEPTH_W-1:0]  depth;
  logic [CNT_W-1:0]    alloc_cnt;
  logic [CNT_W-1:0]    free_cnt;
  logic [NUM_CHUNKS-1:0] slot_valid;

  logic                req;
  logic [SIZE_W-1:0]   size;
  logic [ADDR_W-1:0]   off;
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    dvs;
  logic [STEP_W-1:0]   step;
  logic [IDX_W-1:0]    quo;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    slot;
  logic [STATUS_W-1:0] status;
  logic [PROD_W-1:0]   prod;
  logic [ADDR_W-1:0]   caddr;

  logic [DEPTH_W-1:0]  depth_dec;
  logic                stack_full;
  logic                out_load;
  logic                div_ge;
  logic                range_bad;
  logic                quo_bad;
  logic [DEPTH_W-1:0]  mul_a;
  logic [PROD_W-1:0]   mul_p;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_addr;
  logic [IDX_W-1:0]    ram_rdata;

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == S_IDLE);
  assign depth_dec  = depth - 1'b1;
  assign stack_full = (depth == DEPTH_W'(NUM_CHUNKS));
  assign out_load   = (state == S_DONE) && (!m_tvalid || m_tready);

  // shared compare/subtract step of the restoring divider
  assign div_ge    = (rem >= dvs);
  assign range_bad = (chunk_size == '0) ||
                     (off >= ADDR_W'(REM_W'(chunk_size) << IDX_W));
  assign quo_bad   = (rem != '0) || ({1'b0, quo} >= (IDX_W + 1)'(NUM_CHUNKS));

  // shared multiplier: chunk address offset, then bytes in use
  assign mul_a = (state == S_MUL_ADDR) ? DEPTH_W'(idx) : DEPTH_W'(NUM_CHUNKS) - depth;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(chunk_size);

  // stack ram port
  assign ram_we   = (state == S_DIV_END) && !quo_bad && !stack_full;
  assign ram_addr = (state == S_DIV_END) ? depth[IDX_W-1:0] : depth_dec[IDX_W-1:0];

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_CHUNKS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (quo),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= CS_RESET;
      pool_base  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHUNK_SIZE: chunk_size <= cfg_data[CS_W-1:0];
        REG_POOL_BASE:  pool_base  <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and stack control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth      <= DEPTH_W'(NUM_CHUNKS);
      alloc_cnt  <= '0;
      free_cnt   <= '0;
      slot_valid <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req   <= s_tuser;
            size  <= s_tdata[SIZE_W-1:0];
            off   <= s_tdata[SIZE_W +: ADDR_W] - pool_base;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          idx <= '0;
          if (req == REQ_ALLOC) begin
            if (size > SIZE_W'(chunk_size)) begin
              status <= ST_TOO_LARGE;
              state  <= S_MUL_USED;
            end else if (depth == '0) begin
              status <= ST_EMPTY;
              state  <= S_MUL_USED;
            end else begin
              status    <= ST_OK;
              depth     <= depth_dec;
              slot      <= depth_dec[IDX_W-1:0];
              alloc_cnt <= alloc_cnt + 1'b1;
              state     <= S_ALLOC_RD;
            end
          end else if (range_bad) begin
            status <= ST_BAD_ADDR;
            state  <= S_MUL_USED;
          end else begin
            rem   <= off[REM_W-1:0];
            dvs   <= REM_W'(chunk_size) << (IDX_W - 1);
            step  <= STEP_W'(IDX_W - 1);
            quo   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem <= rem - dvs;
          end
          quo <= {quo[IDX_W-2:0], div_ge};
          dvs <= dvs >> 1;
          if (step == '0) begin
            state <= S_DIV_END;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_DIV_END: begin
          if (quo_bad) begin
            status <= ST_BAD_ADDR;
            state  <= S_MUL_USED;
          end else if (stack_full) begin
            status <= ST_STACK_FULL;
            state  <= S_MUL_USED;
          end else begin
            status <= ST_OK;
            slot_valid[depth[IDX_W-1:0]] <= 1'b1;
            depth    <= depth + 1'b1;
            free_cnt <= free_cnt + 1'b1;
            idx      <= quo;
            state    <= S_MUL_ADDR;
          end
        end
        S_ALLOC_RD: begin
          // an entry never written still holds its own index
          idx   <= slot_valid[slot] ? ram_rdata : slot;
          state <= S_MUL_ADDR;
        end
        S_MUL_ADDR: begin
          prod  <= mul_p;
          state <= S_MUL_USED;
        end
        S_MUL_USED: begin
          caddr <= (status == ST_OK) ? pool_base + ADDR_W'(prod) : '0;
          prod  <= mul_p;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= status;
      m_tdata <= M_TDATA_W'({BYTES_W'(prod), free_cnt, alloc_cnt,
                             FREE_FIELD_W'(depth), caddr, INDEX_FIELD_W'(idx)});
    end
  end

`ifndef SYNTHESIS
  // stack depth stays within the pool
  assert property (@(posedge clk) disable iff (rst) depth <= DEPTH_W'(NUM_CHUNKS))
    else $error("free stack depth beyond pool size");

  // a push never lands on a full stack
  assert property (@(posedge clk) disable iff (rst) ram_we |-> !stack_full)
    else $error("push onto full free stack");

  // a fresh result reports the current stack depth
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> m_tdata[FREE_LSB +: FREE_FIELD_W] == FREE_FIELD_W'(depth))
    else $error("chunks_free does not match stack depth");
`endif

endmodule

FILE: tb/sv/tb_fixed_block_pool_allocator.sv
// Self-checking testbench for fixed_block_pool_allocator: streams allocate and free beats
// through a queue-fed driver and scores every result against an in-bench pool predictor.
// Depends on fbpa_pkg and the allocator RTL only.
module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  // one request beat plus a flag that holds it back until every outstanding result has been received
  typedef struct {
    logic              kind;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    bit                drain;
  } pool_req_t;

  // result tdata fields, lowest field last
  typedef struct packed {
    logic [BYTES_W-1:0]       bytes_used;
    logic [CNT_W-1:0]         frees_done;
    logic [CNT_W-1:0]         allocs_done;
    logic [FREE_FIELD_W-1:0]  free_count;
    logic [ADDR_W-1:0]        address;
    logic [INDEX_FIELD_W-1:0] index;
  } result_fields_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    result_fields_t      f;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // request_size, free_address
  logic s_tuser = 1'b0;                // req_type
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;       // chunk_index, chunk_address, chunks_free,
                                       // alloc_total, free_total, bytes_in_use
  logic [M_TUSER_W-1:0] m_tuser;       // status

  fixed_block_pool_allocator DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial forever #5 clk = ~clk;

  pool_req_t    pending_requests[$];
  pool_result_t expected_results[$];
  pool_req_t    req_on_bus;
  int offered_count  = 0;
  int accepted_count = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cfg_writes     = 0;
  int idle_pct       = 35;
  int status_tally[5] = '{default: 0};

  // predictor state, owned by the monitor
  logic [IDX_W-1:0]   model_stack [NUM_CHUNKS];
  logic [DEPTH_W-1:0] model_depth;
  logic [CNT_W-1:0]   model_allocs;
  logic [CNT_W-1:0]   model_frees;
  logic [CS_W-1:0]    model_chunk_size;
  logic [ADDR_W-1:0]  model_pool_base;

  // generator copy of the configuration, owned by the stimulus process
  logic [CS_W-1:0]   gen_cs = CS_RESET;
  logic [ADDR_W-1:0] gen_base = '0;

  function automatic void reset_pool_model();
    for (int i = 0; i < NUM_CHUNKS; i++) model_stack[i] = IDX_W'(i);
    model_depth      = DEPTH_W'(NUM_CHUNKS);
    model_allocs     = '0;
    model_frees      = '0;
    model_chunk_size = CS_RESET;
    model_pool_base  = '0;
  endfunction

  // applies one request to the pool model and returns the result it must produce
  function automatic pool_result_t serve_request(pool_req_t r);
    pool_result_t res;
    logic [31:0] cs32, offset, quotient, used;
    logic valid_addr;
    res.status = ST_OK;
    res.f = '0;
    cs32 = 32'(model_chunk_size);
    if (r.kind == REQ_ALLOC) begin
      if (32'(r.size) > cs32) begin
        res.status = ST_TOO_LARGE;
      end else if (model_depth == 0) begin
        res.status = ST_EMPTY;
      end else begin
        model_depth = model_depth - 1'b1;
        res.f.index = model_stack[model_depth[IDX_W-1:0]];
        res.f.address = model_pool_base + 32'(res.f.index) * cs32;
        model_allocs = model_allocs + 1'b1;
      end
    end else begin
      offset = r.addr - model_pool_base;
      valid_addr = 1'b0;
      quotient = '0;
      if (cs32 != 0) begin
        if (offset % cs32 == 0) begin
          quotient = offset / cs32;
          valid_addr = quotient < 32'(NUM_CHUNKS);
        end
      end
      if (!valid_addr) begin
        res.status = ST_BAD_ADDR;
      end else if (model_depth >= NUM_CHUNKS) begin
        res.status = ST_STACK_FULL;
      end else begin
        model_stack[model_depth[IDX_W-1:0]] = quotient[IDX_W-1:0];
        model_depth = model_depth + 1'b1;
        res.f.index = quotient[INDEX_FIELD_W-1:0];
        res.f.address = model_pool_base + quotient * cs32;
        model_frees = model_frees + 1'b1;
      end
    end
    used = cs32 * (32'(NUM_CHUNKS) - 32'(model_depth));
    res.f.bytes_used  = used[BYTES_W-1:0];
    res.f.free_count  = model_depth;
    res.f.allocs_done = model_allocs;
    res.f.frees_done  = model_frees;
    return res;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at result %0d, %s: expected 0x%0h, got 0x%0h",
               results_seen, what, want, got);
  endfunction

  // monitor: config beats, accepted requests and result checking
  always @(posedge clk) begin
    pool_result_t want;
    result_fields_t seen;
    if (rst) begin
      reset_pool_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          REG_CHUNK_SIZE: model_chunk_size = cfg_data[CS_W-1:0];
          REG_POOL_BASE:  model_pool_base = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = serve_request(req_on_bus);
        status_tally[want.status]++;
        expected_results.push_back(want);
        accepted_count++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        seen = result_fields_t'(m_tdata[OUT_BITS-1:0]);
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected beat, status", '0, 32'(m_tuser));
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.status) note_mismatch("status", want.status, m_tuser);
          if (seen.index !== want.f.index) note_mismatch("chunk_index", want.f.index, seen.index);
          if (seen.address !== want.f.address)
            note_mismatch("chunk_address", want.f.address, seen.address);
          if (seen.free_count !== want.f.free_count)
            note_mismatch("chunks_free", want.f.free_count, seen.free_count);
          if (seen.allocs_done !== want.f.allocs_done)
            note_mismatch("alloc_total", want.f.allocs_done, seen.allocs_done);
          if (seen.frees_done !== want.f.frees_done)
            note_mismatch("free_total", want.f.frees_done, seen.frees_done);
          if (seen.bytes_used !== want.f.bytes_used)
            note_mismatch("bytes_in_use", want.f.bytes_used, seen.bytes_used);
        end
      end
    end
  end

  // request driver: holds a beat until taken, then pulls the next one
  always @(negedge clk) begin
    pool_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (offered_count == accepted_count) begin
      if (pending_requests.size() != 0 &&
          !(pending_requests[0].drain && expected_results.size() != 0) &&
          $urandom_range(99) >= idle_pct) begin
        nxt = pending_requests.pop_front();
        req_on_bus = nxt;
        offered_count++;
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.kind;
        s_tdata  <= {nxt.addr, nxt.size};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off so the block backs up
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done = 1'b1;
      hold_left = 300;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic add_item(logic kind, logic [15:0] size, logic [31:0] addr, bit drain = 1'b0);
    pool_req_t r;
    r.kind  = kind;
    r.size  = size;
    r.addr  = addr;
    r.drain = drain;
    pending_requests.push_back(r);
  endtask

  function automatic logic [31:0] chunk_at(int idx);
    return gen_base + 32'(idx) * 32'(gen_cs);
  endfunction

  // one random beat: sizes around the chunk size, mostly valid free addresses
  task automatic add_random(int alloc_pct);
    logic [15:0] size;
    logic [31:0] addr;
    size = $urandom;
    addr = $urandom;
    if ($urandom_range(99) < alloc_pct) begin
      case ($urandom_range(9))
        0: ;
        1: size = 16'(gen_cs);
        2: size = 16'(gen_cs) + 1'b1;
        default: size = 16'($urandom_range(32'(gen_cs)));
      endcase
      add_item(REQ_ALLOC, size, addr, $urandom_range(99) == 0);
    end else begin
      case ($urandom_range(9))
        0: ;
        1: addr = chunk_at($urandom_range(NUM_CHUNKS - 1)) + $urandom_range(3, 1);
        2: addr = chunk_at(NUM_CHUNKS + $urandom_range(3));
        default: addr = chunk_at($urandom_range(NUM_CHUNKS - 1));
      endcase
      add_item(REQ_FREE, size, addr, $urandom_range(99) == 0);
    end
  endtask

  // bursts of differing allocate/free mix so the stack depth wanders
  task automatic add_random_run(int count);
    int left, burst, pct;
    left = count;
    while (left > 0) begin
      case ($urandom_range(3))
        0: pct = 15;
        1: pct = 50;
        2: pct = 85;
        default: pct = 97;
      endcase
      burst = $urandom_range(50, 15);
      if (burst > left) burst = left;
      repeat (burst) add_random(pct);
      left -= burst;
    end
  endtask

  task automatic wait_pool_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || offered_count != accepted_count ||
           expected_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_pool_config(logic [31:0] cs_word, logic [31:0] base);
    wait_pool_idle();
    write_register(REG_CHUNK_SIZE, cs_word);
    write_register(REG_POOL_BASE, base);
    gen_cs   = cs_word[CS_W-1:0];
    gen_base = base;
    @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // reset config: size limits, address checks, double free on a full stack
    add_item(REQ_ALLOC, 16'd0, 32'hFFFF_FFFF);
    add_item(REQ_ALLOC, 16'd64, 32'h0);
    add_item(REQ_ALLOC, 16'd65, 32'h0);
    add_item(REQ_ALLOC, 16'hFFFF, 32'hFFFF_FFFF);
    add_item(REQ_FREE, 16'hFFFF, chunk_at(254));
    add_item(REQ_FREE, 16'h0, chunk_at(254) + 1);
    add_item(REQ_FREE, 16'h0, chunk_at(NUM_CHUNKS));
    add_item(REQ_FREE, 16'h0, 32'hFFFF_FFFF);
    add_item(REQ_FREE, 16'h0, chunk_at(255));
    add_item(REQ_FREE, 16'h0, chunk_at(0));
    add_item(REQ_ALLOC, 16'd1, 32'h0);
    add_item(REQ_FREE, 16'h0, chunk_at(0));
    add_item(REQ_FREE, 16'h0, chunk_at(63));
    add_item(REQ_ALLOC, 16'd0, 32'h0);
    add_item(REQ_FREE, 16'h0, chunk_at(255), 1'b1);
    add_random_run(100);

    // one-byte chunks at the top of the address space, addresses wrap to zero
    set_pool_config(32'd1, 32'hFFFF_FFFF);
    add_item(REQ_ALLOC, 16'd1, 32'h0);
    add_item(REQ_ALLOC, 16'd2, 32'h0);
    add_item(REQ_FREE, 16'h0, chunk_at(0));
    add_item(REQ_FREE, 16'h0, chunk_at(255));
    add_item(REQ_FREE, 16'h0, chunk_at(256));
    add_random_run(100);

    // largest nominal chunks, no idling: drain the pool fully, then random traffic
    set_pool_config(32'd4096, 32'hFFF0_0000);
    idle_pct = 0;
    repeat (NUM_CHUNKS + 4) add_item(REQ_ALLOC, 16'($urandom_range(4096)), $urandom);
    add_item(REQ_ALLOC, 16'd4097, 32'h0);
    add_item(REQ_ALLOC, 16'd0, 32'h0);
    add_random_run(100);
    wait_pool_idle();
    idle_pct = 35;

    // oversize chunk size, upper write bits set and dropped
    set_pool_config(32'hFFFF_FFFF, $urandom);
    add_random_run(100);

    // zero chunk size: only zero-byte allocations, every free rejected
    set_pool_config(32'hABCD_E000, $urandom);
    add_item(REQ_ALLOC, 16'd0, 32'h0, 1'b1);
    add_item(REQ_ALLOC, 16'd1, 32'h0);
    add_item(REQ_FREE, 16'h0, gen_base);
    add_random_run(20);

    // arbitrary geometry
    set_pool_config($urandom_range(300, 1), $urandom);
    add_random_run(100);

    // back to reset values
    set_pool_config(32'(CS_RESET), 32'h0);
    add_random_run(40);

    wait_pool_idle();
    $display("checked %0d results over %0d register writes, %0d mismatches",
             results_seen, cfg_writes, mismatches);
    $display("outcomes: ok %0d, too large %0d, pool empty %0d, bad address %0d, stack full %0d",
             status_tally[ST_OK], status_tally[ST_TOO_LARGE], status_tally[ST_EMPTY],
             status_tally[ST_BAD_ADDR], status_tally[ST_STACK_FULL]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("timeout with %0d results still outstanding", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
